>>> hw/rtl/pst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pst_pkg
// Types, sizes and action codes shared by the publish/subscribe table.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int SIGNAL_SLOTS  = 8;
	localparam int SUBS_PER_SLOT = 8;
	localparam int NUM_CELLS     = SIGNAL_SLOTS * SUBS_PER_SLOT;

	localparam int SLOT_W = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;
	localparam int CELL_W = (SUBS_PER_SLOT > 1) ? $clog2(SUBS_PER_SLOT) : 1;
	localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

	localparam logic [2:0] ACT_CLEAR       = 3'd0;
	localparam logic [2:0] ACT_SUBSCRIBE   = 3'd1;
	localparam logic [2:0] ACT_UNSUBSCRIBE = 3'd2;
	localparam logic [2:0] ACT_QUERY       = 3'd3;
	localparam logic [2:0] ACT_PUBLISH     = 3'd4;

	localparam logic [8:0] LIMIT_RESET = 9'd256;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  signal_type;
		logic [7:0]  subscriber_id;
		logic [31:0] payload_tag;
		logic [15:0] payload_size;
	} req_t;

	typedef struct packed {
		logic        item_kind;
		logic        success;
		logic [7:0]  target_subscriber;
		logic [7:0]  delivered_type;
		logic [31:0] delivered_tag;
		logic [15:0] delivered_size;
		logic        last;
	} rsp_t;

endpackage
`default_nettype wire

>>> hw/rtl/pst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/publish_subscribe_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// publish_subscribe_table
// Registry of signal slots with subscriber cells held in a RAM; performs
// clear, subscribe, unsubscribe, query and publish requests.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  req       req_valid / req_stall   req_item  (pst_pkg::req_t)
//  rsp       rsp_valid / rsp_stall   rsp_item  (pst_pkg::rsp_t)
//  cfg       cfg_valid / cfg_ready   cfg_data  (signal_type_limit)
//
//  Subscribe, unsubscribe, query and publish sweep every cell of the RAM,
//  one read a cycle while no delivery is held. Clear and rejected requests
//  skip the sweep and go straight to the final reply. Each delivery that
//  meets a stalled output holds the sweep for as long as the stall lasts.
//  Reset empties the table at once through per-cell valid flops.
// ----------------------------------------------------------------------------
module publish_subscribe_table (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pst_pkg::req_t req_item,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pst_pkg::rsp_t      rsp_item,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [8:0]    cfg_data
);

	import pst_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;

	logic [8:0] limit_q;
	req_t       req_q;
	logic       type_ok_q;

	logic [SIGNAL_SLOTS-1:0] slot_in_use_q;
	logic [7:0]              slot_sig_q [SIGNAL_SLOTS];
	logic [NUM_CELLS-1:0]    cell_vld_q;

	// Sweep issue side and the stage whose RAM data is returning.
	logic              issue_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CELL_W-1:0] cell_q;
	logic [ADDR_W-1:0] addr_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [CELL_W-1:0] cell_s1;
	logic [ADDR_W-1:0] addr_s1;

	logic              present_q;
	logic              empty_found_q;
	logic [ADDR_W-1:0] empty_addr_q;
	logic              unsub_done_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	logic [SIGNAL_SLOTS-1:0] slot_match;
	logic                    has_match;
	logic [SLOT_W-1:0]       pub_slot;
	logic                    free_any;
	logic [SLOT_W-1:0]       free_slot;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	logic [7:0] cell_val;
	logic       slot_hit;
	logic       id_hit;
	logic       cell_empty;
	logic       pub_emit;
	logic       rsp_free;
	logic       rsp_load;
	logic       hold;
	logic       step;
	logic       last_issue;
	logic       last_eval;
	logic       accept;
	logic       need_scan;
	logic       id_ok;
	logic       fin_ok;
	logic       sub_new_cell;
	logic       sub_new_slot;
	logic [ADDR_W-1:0] free_addr;

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign id_ok     = (req_q.subscriber_id != 8'd0);

	// Publish needs only a valid type; the other sweeping actions also need an id.
	always_comb begin
		need_scan = 1'b0;
		if ({1'b0, req_item.signal_type} < limit_q) begin
			if (req_item.action == ACT_PUBLISH) begin
				need_scan = 1'b1;
			end else if ((req_item.action == ACT_SUBSCRIBE ||
			              req_item.action == ACT_UNSUBSCRIBE ||
			              req_item.action == ACT_QUERY) &&
			             req_item.subscriber_id != 8'd0) begin
				need_scan = 1'b1;
			end
		end
	end

	always_comb begin
		has_match = 1'b0;
		pub_slot  = '0;
		free_any  = 1'b0;
		free_slot = '0;
		for (int s = SIGNAL_SLOTS - 1; s >= 0; s--) begin
			slot_match[s] = slot_in_use_q[s] && (slot_sig_q[s] == req_q.signal_type);
			if (slot_match[s]) begin
				has_match = 1'b1;
				pub_slot  = SLOT_W'(s);
			end
			if (!slot_in_use_q[s]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(s);
			end
		end
	end

	assign free_addr = ADDR_W'(free_slot) * ADDR_W'(SUBS_PER_SLOT);

	assign cell_val   = cell_vld_q[addr_s1] ? ram_rdata : 8'd0;
	assign slot_hit   = slot_match[slot_s1];
	assign id_hit     = slot_hit && (cell_val == req_q.subscriber_id);
	assign cell_empty = slot_hit && (cell_val == 8'd0);
	assign pub_emit   = vld_s1 && (req_q.action == ACT_PUBLISH) && has_match &&
	                    (slot_s1 == pub_slot) && (cell_val != 8'd0);
	assign hold       = pub_emit && !rsp_free;
	assign step       = vld_s1 && !hold;
	assign last_issue = (slot_q == SLOT_W'(SIGNAL_SLOTS - 1)) &&
	                    (cell_q == CELL_W'(SUBS_PER_SLOT - 1));
	assign last_eval  = step && (slot_s1 == SLOT_W'(SIGNAL_SLOTS - 1)) &&
	                    (cell_s1 == CELL_W'(SUBS_PER_SLOT - 1));
	assign ram_raddr  = hold ? addr_s1 : addr_q;
	assign rsp_load   = rsp_free && ((state_q == ST_SCAN && pub_emit) ||
	                                 state_q == ST_FINISH);

	assign sub_new_cell = !present_q && empty_found_q;
	assign sub_new_slot = !present_q && !empty_found_q && free_any;

	always_comb begin
		unique case (req_q.action)
			ACT_CLEAR:       fin_ok = 1'b1;
			ACT_SUBSCRIBE:   fin_ok = type_ok_q && id_ok &&
			                          (present_q || empty_found_q || free_any);
			ACT_UNSUBSCRIBE: fin_ok = type_ok_q && id_ok && unsub_done_q;
			ACT_QUERY:       fin_ok = type_ok_q && id_ok && present_q;
			ACT_PUBLISH:     fin_ok = type_ok_q && has_match;
			default:         fin_ok = 1'b0;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = empty_addr_q;
		ram_wdata = req_q.subscriber_id;
		if (state_q == ST_FINISH && rsp_free && fin_ok &&
		    req_q.action == ACT_SUBSCRIBE) begin
			if (sub_new_cell) begin
				ram_we = 1'b1;
			end else if (sub_new_slot) begin
				ram_we    = 1'b1;
				ram_waddr = free_addr;
			end
		end
	end

	pst_ram #(
		.WIDTH(8),
		.DEPTH(NUM_CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			limit_q       <= LIMIT_RESET;
			type_ok_q     <= 1'b0;
			slot_in_use_q <= '0;
			cell_vld_q    <= '0;
			issue_q       <= 1'b0;
			slot_q        <= '0;
			cell_q        <= '0;
			addr_q        <= '0;
			vld_s1        <= 1'b0;
			present_q     <= 1'b0;
			empty_found_q <= 1'b0;
			unsub_done_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_free) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						type_ok_q     <= ({1'b0, req_item.signal_type} < limit_q);
						present_q     <= 1'b0;
						empty_found_q <= 1'b0;
						unsub_done_q  <= 1'b0;
						slot_q        <= '0;
						cell_q        <= '0;
						addr_q        <= '0;
						issue_q       <= need_scan;
						state_q       <= need_scan ? ST_SCAN : ST_FINISH;
					end
				end
				ST_SCAN: begin
					if (!hold) begin
						vld_s1 <= issue_q;
						if (issue_q) begin
							addr_q <= addr_q + 1'b1;
							if (cell_q == CELL_W'(SUBS_PER_SLOT - 1)) begin
								cell_q <= '0;
								slot_q <= slot_q + 1'b1;
							end else begin
								cell_q <= cell_q + 1'b1;
							end
							if (last_issue) begin
								issue_q <= 1'b0;
							end
						end
					end
					if (step) begin
						if (id_hit) begin
							present_q <= 1'b1;
						end
						if (cell_empty && !empty_found_q) begin
							empty_found_q <= 1'b1;
						end
						// Unsubscribe empties only the first cell that holds the id.
						if (req_q.action == ACT_UNSUBSCRIBE && id_hit && !unsub_done_q) begin
							unsub_done_q         <= 1'b1;
							cell_vld_q[addr_s1]  <= 1'b0;
						end
					end
					if (last_eval) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					vld_s1 <= 1'b0;
					if (rsp_free) begin
						state_q     <= ST_IDLE;
						if (req_q.action == ACT_CLEAR) begin
							slot_in_use_q <= '0;
							cell_vld_q    <= '0;
						end else if (req_q.action == ACT_SUBSCRIBE && fin_ok) begin
							if (sub_new_cell) begin
								cell_vld_q[empty_addr_q] <= 1'b1;
							end else if (sub_new_slot) begin
								slot_in_use_q[free_slot] <= 1'b1;
								cell_vld_q[free_addr]    <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_item;
		end
		if (state_q == ST_SCAN && !hold && issue_q) begin
			slot_s1 <= slot_q;
			cell_s1 <= cell_q;
			addr_s1 <= addr_q;
		end
		if (state_q == ST_SCAN && step && cell_empty && !empty_found_q) begin
			empty_addr_q <= addr_s1;
		end
		if (state_q == ST_FINISH && rsp_free && sub_new_slot && fin_ok &&
		    req_q.action == ACT_SUBSCRIBE) begin
			slot_sig_q[free_slot] <= req_q.signal_type;
		end
		if (state_q == ST_SCAN && pub_emit && rsp_free) begin
			rsp_q.item_kind         <= 1'b0;
			rsp_q.success           <= 1'b0;
			rsp_q.target_subscriber <= cell_val;
			rsp_q.delivered_type    <= req_q.signal_type;
			rsp_q.delivered_tag     <= req_q.payload_tag;
			rsp_q.delivered_size    <= req_q.payload_size;
			rsp_q.last              <= 1'b0;
		end else if (state_q == ST_FINISH && rsp_free) begin
			rsp_q.item_kind         <= 1'b1;
			rsp_q.success           <= fin_ok;
			rsp_q.target_subscriber <= 8'd0;
			rsp_q.delivered_type    <= 8'd0;
			rsp_q.delivered_tag     <= 32'd0;
			rsp_q.delivered_size    <= 16'd0;
			rsp_q.last              <= 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> verif/tb_publish_subscribe_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_publish_subscribe_table
// Self-checking bench for the publish/subscribe table. A driver feeds queued
// requests and a monitor predicts every response from its own copy of the
// registry. Responses are compared field by field as they arrive. Random
// stalls hit responses, gaps hit requests. The type limit changes by phase.
// ----------------------------------------------------------------------------
module tb_publish_subscribe_table;
	import pst_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD    = 600;

	// Action codes that the block does not define.
	localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
	localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_t       req_item  = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_t       rsp_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [8:0] cfg_data  = '0;

	// Predicted registry contents.
	bit [8:0] type_limit = LIMIT_RESET;
	bit       slot_used [SIGNAL_SLOTS];
	bit [7:0] slot_sig  [SIGNAL_SLOTS];
	bit [7:0] cell_id   [NUM_CELLS];

	req_t request_queue [$];
	rsp_t predicted_rsp [$];
	rsp_t want;

	bit [7:0] type_pool [4];
	bit [7:0] id_pool   [6];

	int error_count    = 0;
	int queued_count   = 0;
	int accepted_count = 0;
	bit req_accepted   = 1'b0;
	bit idle_on        = 1'b1;
	int gap_left       = 0;
	int stall_left     = 0;
	int hold_cycles    = 0;

	publish_subscribe_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic bit pair_present(input bit [7:0] sig, input bit [7:0] id);
		bit hit;
		hit = 1'b0;
		for (int s = 0; s < SIGNAL_SLOTS; s++)
			for (int c = 0; c < SUBS_PER_SLOT; c++)
				if (slot_used[s] && slot_sig[s] == sig && cell_id[s*SUBS_PER_SLOT+c] == id)
					hit = 1'b1;
		return hit;
	endfunction

	// Applies one request to the predicted registry and queues its responses.
	task automatic apply_request(input req_t r);
		bit   ok;
		bit   id_ok;
		bit   type_ok;
		bit   found;
		int   free_slot;
		rsp_t note;
		ok        = 1'b0;
		found     = 1'b0;
		free_slot = -1;
		type_ok   = {1'b0, r.signal_type} < type_limit;
		id_ok     = (r.subscriber_id != 8'd0) && type_ok;
		case (r.action)
			ACT_CLEAR: begin
				for (int s = 0; s < SIGNAL_SLOTS; s++)
					slot_used[s] = 1'b0;
				for (int n = 0; n < NUM_CELLS; n++)
					cell_id[n] = 8'd0;
				ok = 1'b1;
			end
			ACT_SUBSCRIBE: begin
				if (id_ok && pair_present(r.signal_type, r.subscriber_id)) begin
					ok = 1'b1;
				end else if (id_ok) begin
					// The first matching slot with room wins; otherwise the first free slot.
					for (int s = 0; s < SIGNAL_SLOTS && !ok; s++) begin
						if (slot_used[s] && slot_sig[s] == r.signal_type) begin
							for (int c = 0; c < SUBS_PER_SLOT && !ok; c++)
								if (cell_id[s*SUBS_PER_SLOT+c] == 8'd0) begin
									cell_id[s*SUBS_PER_SLOT+c] = r.subscriber_id;
									ok = 1'b1;
								end
						end else if (!slot_used[s] && free_slot < 0) begin
							free_slot = s;
						end
					end
					if (!ok && free_slot >= 0) begin
						slot_used[free_slot]              = 1'b1;
						slot_sig[free_slot]               = r.signal_type;
						cell_id[free_slot*SUBS_PER_SLOT] = r.subscriber_id;
						ok = 1'b1;
					end
				end
			end
			ACT_UNSUBSCRIBE: begin
				if (id_ok)
					for (int s = 0; s < SIGNAL_SLOTS && !ok; s++)
						if (slot_used[s] && slot_sig[s] == r.signal_type)
							for (int c = 0; c < SUBS_PER_SLOT && !ok; c++)
								if (cell_id[s*SUBS_PER_SLOT+c] == r.subscriber_id) begin
									cell_id[s*SUBS_PER_SLOT+c] = 8'd0;
									ok = 1'b1;
								end
			end
			ACT_QUERY: begin
				ok = id_ok && pair_present(r.signal_type, r.subscriber_id);
			end
			ACT_PUBLISH: begin
				if (type_ok)
					for (int s = 0; s < SIGNAL_SLOTS; s++)
						if (!found && slot_used[s] && slot_sig[s] == r.signal_type) begin
							found = 1'b1;
							for (int c = 0; c < SUBS_PER_SLOT; c++)
								if (cell_id[s*SUBS_PER_SLOT+c] != 8'd0) begin
									note                   = '0;
									note.target_subscriber = cell_id[s*SUBS_PER_SLOT+c];
									note.delivered_type    = r.signal_type;
									note.delivered_tag     = r.payload_tag;
									note.delivered_size    = r.payload_size;
									predicted_rsp.push_back(note);
								end
						end
				ok = found;
			end
			default: ;
		endcase
		note           = '0;
		note.item_kind = 1'b1;
		note.success   = ok;
		note.last      = 1'b1;
		predicted_rsp.push_back(note);
	endtask

	task automatic flag_field(input string label, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, label, exp_val, got_val);
			error_count++;
		end
	endtask

	task automatic queue_request(input logic [2:0] act, input logic [7:0] sig,
			input logic [7:0] id, input logic [31:0] tag, input logic [15:0] size);
		req_t r;
		r.action        = act;
		r.signal_type   = sig;
		r.subscriber_id = id;
		r.payload_tag   = tag;
		r.payload_size  = size;
		request_queue.push_back(r);
		queued_count++;
	endtask

	task automatic draw_pools(input int lo, input int hi);
		for (int n = 0; n < 4; n++)
			type_pool[n] = 8'($urandom_range(lo, hi));
		for (int n = 0; n < 6; n++)
			id_pool[n] = 8'($urandom_range(1, 255));
	endtask

	// Mostly subscribe/publish traffic on a few types and ids so that slots
	// fill, overflow and get delivered from; the rest is noise.
	task automatic queue_random(input int count);
		int       pick;
		bit [2:0] act;
		bit [7:0] sig;
		bit [7:0] id;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				act = ACT_CLEAR;
			else if (pick < 40)
				act = ACT_SUBSCRIBE;
			else if (pick < 55)
				act = ACT_UNSUBSCRIBE;
			else if (pick < 70)
				act = ACT_QUERY;
			else if (pick < 97)
				act = ACT_PUBLISH;
			else
				act = 3'($urandom_range(ACT_RESERVED_LO, ACT_RESERVED_HI));
			if ($urandom_range(0, 9) == 0)
				sig = 8'($urandom_range(0, 255));
			else
				sig = type_pool[$urandom_range(0, 3)];
			if ($urandom_range(0, 9) == 0)
				id = 8'($urandom_range(0, 255));
			else
				id = id_pool[$urandom_range(0, 5)];
			queue_request(act, sig, id, $urandom(), 16'($urandom_range(0, 65535)));
		end
	endtask

	// The sender waits here until every request is answered and the block is quiet.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (accepted_count != queued_count || predicted_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [8:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		type_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Request driver.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_accepted) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 4) == 0) begin
					gap_left  = $urandom_range(0, 3);
					req_valid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					req_item  <= request_queue.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response back-pressure.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 3);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Monitor: prediction on each accepted request, then the response check.
	always @(posedge clk) begin
		if (arst_n) begin
			req_accepted = req_valid && !req_stall;
			if (req_accepted) begin
				apply_request(req_item);
				accepted_count++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (predicted_rsp.size() == 0) begin
					$display("%0t ns: unexpected response, expected none, actual %h",
						$time, rsp_item);
					error_count++;
				end else begin
					want = predicted_rsp.pop_front();
					flag_field("item_kind", 32'(want.item_kind), 32'(rsp_item.item_kind));
					flag_field("success", 32'(want.success), 32'(rsp_item.success));
					flag_field("target_subscriber", 32'(want.target_subscriber),
						32'(rsp_item.target_subscriber));
					flag_field("delivered_type", 32'(want.delivered_type),
						32'(rsp_item.delivered_type));
					flag_field("delivered_tag", want.delivered_tag, rsp_item.delivered_tag);
					flag_field("delivered_size", 32'(want.delivered_size),
						32'(rsp_item.delivered_size));
					flag_field("last", 32'(want.last), 32'(rsp_item.last));
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_limit(9'd256);
		// Nothing subscribed yet, then every request with a null subscriber.
		queue_request(ACT_PUBLISH, 8'd5, 8'd0, 32'hFFFF_FFFF, 16'hFFFF);
		queue_request(ACT_SUBSCRIBE, 8'd5, 8'd0, 32'h0, 16'h0);
		queue_request(ACT_UNSUBSCRIBE, 8'd5, 8'd0, 32'h0, 16'h0);
		queue_request(ACT_QUERY, 8'd5, 8'd0, 32'h0, 16'h0);
		// The repeated pair must succeed without taking a second cell.
		queue_request(ACT_SUBSCRIBE, 8'd5, 8'd1, 32'h0, 16'h0);
		queue_request(ACT_SUBSCRIBE, 8'd5, 8'd1, 32'h0, 16'h0);
		queue_request(ACT_SUBSCRIBE, 8'd5, 8'd255, 32'h0, 16'h0);
		queue_request(ACT_SUBSCRIBE, 8'd0, 8'd1, 32'h0, 16'h0);
		queue_request(ACT_SUBSCRIBE, 8'd255, 8'd255, 32'h0, 16'h0);
		queue_request(ACT_QUERY, 8'd5, 8'd255, 32'h0, 16'h0);
		queue_request(ACT_QUERY, 8'd5, 8'd2, 32'h0, 16'h0);
		// Fill the first slot of type 5; the next subscriber opens a second one.
		for (int n = 2; n < 8; n++)
			queue_request(ACT_SUBSCRIBE, 8'd5, 8'(n), 32'h0, 16'h0);
		queue_request(ACT_SUBSCRIBE, 8'd5, 8'd9, 32'h0, 16'h0);
		queue_request(ACT_PUBLISH, 8'd5, 8'd77, 32'h0, 16'h0);
		queue_request(ACT_UNSUBSCRIBE, 8'd5, 8'd1, 32'h0, 16'h0);
		queue_request(ACT_UNSUBSCRIBE, 8'd5, 8'd1, 32'h0, 16'h0);
		// Use up the remaining slots, then a new type finds the table full.
		for (int n = 10; n < 14; n++)
			queue_request(ACT_SUBSCRIBE, 8'(n), 8'd1, 32'h0, 16'h0);
		queue_request(ACT_SUBSCRIBE, 8'd20, 8'd1, 32'h0, 16'h0);
		// An emptied slot still matches, so the publish succeeds with no deliveries.
		queue_request(ACT_UNSUBSCRIBE, 8'd0, 8'd1, 32'h0, 16'h0);
		queue_request(ACT_PUBLISH, 8'd0, 8'd0, 32'hA5A5_5A5A, 16'h5A5A);
		queue_request(ACT_RESERVED_LO, 8'd5, 8'd1, 32'h0, 16'h0);
		queue_request(ACT_RESERVED_HI, 8'd5, 8'd1, 32'h0, 16'h0);
		queue_request(ACT_CLEAR, 8'd0, 8'd0, 32'h0, 16'h0);
		queue_request(ACT_PUBLISH, 8'd5, 8'd0, 32'h1234_5678, 16'h9ABC);
		wait_idle();

		draw_pools(0, 255);
		queue_random(20);
		wait_idle();

		// Hold the output for a long stretch so the block backs up onto its input.
		@(posedge clk);
		hold_cycles = LONG_HOLD;
		queue_random(15);
		wait_idle();

		write_limit(9'd155);
		draw_pools(120, 190);
		queue_random(10);
		wait_idle();

		write_limit(9'd100);
		draw_pools(80, 120);
		queue_random(8);
		wait_idle();

		write_limit(9'd1);
		draw_pools(0, 2);
		queue_request(ACT_SUBSCRIBE, 8'd0, 8'd3, 32'h0, 16'h0);
		queue_request(ACT_SUBSCRIBE, 8'd1, 8'd3, 32'h0, 16'h0);
		queue_random(5);
		wait_idle();

		// With a limit of zero only a clear can succeed.
		write_limit(9'd0);
		queue_random(5);
		queue_request(ACT_CLEAR, 8'd0, 8'd0, 32'h0, 16'h0);
		wait_idle();

		write_limit(9'd256);
		idle_on = 1'b0;
		draw_pools(0, 255);
		queue_random(10);
		wait_idle();

		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/pst_pkg.sv
hw/rtl/pst_ram.sv
hw/rtl/publish_subscribe_table.sv
verif/tb_publish_subscribe_table.sv
